// ----- rtl/rvx_pkg.sv -----
// Shared types, opcodes and constants for the RV32I subset execute core.
`timescale 1ns / 1ps

package rvx_pkg;

    // Default data memory size in bytes
    localparam int unsigned MEM_BYTES_DEFAULT = 4096;

    // Entries in the decode-to-execute queue
    localparam int unsigned QUEUE_DEPTH = 2;

    // Register file geometry
    localparam int unsigned NUM_REGS = 32;
    localparam int unsigned REG_IDX_W = 5;
    localparam logic [REG_IDX_W-1:0] REG_SP = 5'd2;
    localparam logic [REG_IDX_W-1:0] REG_ZERO = 5'd0;

    // Major opcodes
    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JAL    = 7'h6F;

    // funct3 / funct7 codes
    localparam logic [2:0] F3_ADD_SUB = 3'd0;
    localparam logic [2:0] F3_BEQ     = 3'd0;
    localparam logic [2:0] F3_BNE     = 3'd1;
    localparam logic [6:0] F7_BASE    = 7'h00;
    localparam logic [6:0] F7_SUB     = 7'h20;

    // Operation class decided by the front end
    typedef enum logic [2:0] {
        OP_NOP,
        OP_ZERO,
        OP_ADDI,
        OP_ADD,
        OP_SUB,
        OP_BEQ,
        OP_BNE,
        OP_JAL
    } op_class_t;

    // Input transaction
    typedef struct packed {
        logic [31:0] instr_word;
        logic [4:0]  peek_index;
    } instr_t;

    // Output transaction
    typedef struct packed {
        logic [31:0]        next_pc;
        logic               halted;
        logic               write_enable;
        logic [4:0]         write_index;
        logic signed [31:0] write_value;
        logic signed [31:0] peek_value;
        logic [63:0]        retired_count;
    } result_t;

    // Decoded instruction held in the queue
    typedef struct packed {
        op_class_t             cls;
        logic [REG_IDX_W-1:0]  rd;
        logic [REG_IDX_W-1:0]  rs1;
        logic [REG_IDX_W-1:0]  rs2;
        logic [REG_IDX_W-1:0]  peek;
        logic [31:0]           imm;
    } uop_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic valid;
        uop_t uop;
    } q_head_t;

endpackage

// ----- rtl/rvx_front.sv -----
// Front end: accepts instruction transactions and decodes them into queue entries.
`timescale 1ns / 1ps

module rvx_front
(
    input  logic              instr_valid,
    output logic              instr_stall,
    input  rvx_pkg::instr_t   instr,
    input  logic              q_full,
    output logic              push,
    output rvx_pkg::uop_t     uop
);

    logic [31:0] w;
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;

    assign w   = instr.instr_word;
    assign opc = w[6:0];
    assign f3  = w[14:12];
    assign f7  = w[31:25];

    // Handshake: take a transaction whenever the queue has room
    assign instr_stall = q_full;
    assign push        = instr_valid && !q_full;

    // Decode
    always_comb
    begin
        uop      = '0;
        uop.cls  = rvx_pkg::OP_NOP;
        uop.rd   = w[11:7];
        uop.rs1  = w[19:15];
        uop.rs2  = w[24:20];
        uop.peek = instr.peek_index;
        uop.imm  = '0;
        if (w == '0)
        begin
            uop.cls = rvx_pkg::OP_ZERO;
        end
        else
        begin
            unique case (opc)
                rvx_pkg::OPC_OP_IMM:
                begin
                    // every funct3 executes as ADDI
                    uop.cls = rvx_pkg::OP_ADDI;
                    uop.imm = {{20{w[31]}}, w[31:20]};
                end
                rvx_pkg::OPC_OP:
                begin
                    if (f3 == rvx_pkg::F3_ADD_SUB && f7 == rvx_pkg::F7_BASE)
                    begin
                        uop.cls = rvx_pkg::OP_ADD;
                    end
                    else if (f3 == rvx_pkg::F3_ADD_SUB && f7 == rvx_pkg::F7_SUB)
                    begin
                        uop.cls = rvx_pkg::OP_SUB;
                    end
                end
                rvx_pkg::OPC_BRANCH:
                begin
                    uop.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                    if (f3 == rvx_pkg::F3_BEQ)
                    begin
                        uop.cls = rvx_pkg::OP_BEQ;
                    end
                    else if (f3 == rvx_pkg::F3_BNE)
                    begin
                        uop.cls = rvx_pkg::OP_BNE;
                    end
                end
                rvx_pkg::OPC_JAL:
                begin
                    uop.cls = rvx_pkg::OP_JAL;
                    uop.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
                end
                default:
                begin
                    uop.cls = rvx_pkg::OP_NOP;
                end
            endcase
        end
    end

endmodule

// ----- rtl/rvx_queue.sv -----
// Small FIFO of decoded instructions between front and back end.
`timescale 1ns / 1ps

module rvx_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rvx_pkg::uop_t      push_uop,
    output logic               full,
    input  logic               pop,
    output rvx_pkg::q_head_t   head
);

    localparam int unsigned DEPTH = rvx_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rvx_pkg::uop_t     entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.uop   = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_uop;
        end
    end

    // Assertions
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue occupancy above depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (push == pop) |=> $stable(count_reg))
        else $error("queue occupancy changed without net push or pop");

endmodule

// ----- rtl/rvx_back.sv -----
// Back end: register file, pc, retire counter, execute stage and output register.
`timescale 1ns / 1ps

module rvx_back
#(
    parameter int unsigned MEM_BYTES = rvx_pkg::MEM_BYTES_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  rvx_pkg::q_head_t   head,
    output logic               pop,
    output logic               result_valid,
    input  logic               result_stall,
    output rvx_pkg::result_t   result
);

    localparam int unsigned NREG = rvx_pkg::NUM_REGS;
    localparam int unsigned IW   = rvx_pkg::REG_IDX_W;

    // Register file: two copies, one for source operands, one for the peek port
    logic [31:0]         rf_src_mem  [NREG];
    logic [31:0]         rf_peek_mem [NREG];
    logic [NREG-1:0]     rf_written_reg;

    // Execute stage
    logic                ex_valid_reg;
    logic                ex_valid_next;
    rvx_pkg::uop_t       ex_uop_reg;
    rvx_pkg::uop_t       ex_uop_next;
    logic [31:0]         rs1_data_reg;
    logic [31:0]         rs2_data_reg;
    logic [31:0]         peek_data_reg;
    logic                rs1_wr_reg;
    logic                rs2_wr_reg;
    logic                peek_wr_reg;

    // Last committed write, for bypass
    logic                lw_en_reg;
    logic [IW-1:0]       lw_idx_reg;
    logic [31:0]         lw_val_reg;

    // Architectural state
    logic [31:0]         pc_reg;
    logic [31:0]         pc_next;
    logic [63:0]         retired_reg;
    logic [63:0]         retired_next;

    // Output register
    logic                out_valid_reg;
    logic                out_valid_next;
    rvx_pkg::result_t    out_reg;
    rvx_pkg::result_t    out_next;

    logic                out_free;
    logic                ex_fire;
    logic                ex_adv;
    logic                halt;
    logic [31:0]         op_a;
    logic [31:0]         op_b;
    logic [31:0]         wv;
    logic                wr;
    logic                we;
    logic                take;
    logic [31:0]         npc;
    logic [31:0]         pc_plus4;

    // Register value seen by the execute stage: bypass, stored, or reset value
    function automatic logic [31:0] reg_value(
        input logic [IW-1:0] idx,
        input logic [31:0]   data,
        input logic          written,
        input logic          byp_en,
        input logic [IW-1:0] byp_idx,
        input logic [31:0]   byp_val
    );
        logic [31:0] v;
        if (byp_en && byp_idx == idx)
        begin
            v = byp_val;
        end
        else if (written)
        begin
            v = data;
        end
        else if (idx == rvx_pkg::REG_SP)
        begin
            v = 32'(MEM_BYTES);
        end
        else
        begin
            v = '0;
        end
        return v;
    endfunction

    // Stage control
    assign out_free = !out_valid_reg || !result_stall;
    assign ex_fire  = ex_valid_reg && out_free;
    assign ex_adv   = !ex_valid_reg || ex_fire;
    assign pop      = head.valid && ex_adv;

    always_comb
    begin
        if (ex_adv)
        begin
            ex_valid_next = head.valid;
            ex_uop_next   = head.uop;
        end
        else
        begin
            ex_valid_next = ex_valid_reg;
            ex_uop_next   = ex_uop_reg;
        end
    end

    // Execute
    always_comb
    begin
        op_a = reg_value(ex_uop_reg.rs1, rs1_data_reg, rs1_wr_reg,
                         lw_en_reg, lw_idx_reg, lw_val_reg);
        op_b = reg_value(ex_uop_reg.rs2, rs2_data_reg, rs2_wr_reg,
                         lw_en_reg, lw_idx_reg, lw_val_reg);
        halt = (ex_uop_reg.cls == rvx_pkg::OP_ZERO) ||
               (({1'b0, pc_reg} + 33'd3) >= 33'(MEM_BYTES));
        pc_plus4 = pc_reg + 32'd4;
        wv   = '0;
        wr   = 1'b0;
        take = 1'b0;
        npc  = pc_plus4;
        case (ex_uop_reg.cls)
            rvx_pkg::OP_ADDI:
            begin
                wv = op_a + ex_uop_reg.imm;
                wr = 1'b1;
            end
            rvx_pkg::OP_ADD:
            begin
                wv = op_a + op_b;
                wr = 1'b1;
            end
            rvx_pkg::OP_SUB:
            begin
                wv = op_a - op_b;
                wr = 1'b1;
            end
            rvx_pkg::OP_BEQ:
            begin
                take = (op_a == op_b);
            end
            rvx_pkg::OP_BNE:
            begin
                take = (op_a != op_b);
            end
            rvx_pkg::OP_JAL:
            begin
                wv   = pc_plus4;
                wr   = 1'b1;
                take = 1'b1;
            end
            default:
            begin
                wr = 1'b0;
            end
        endcase
        if (take)
        begin
            npc = pc_reg + ex_uop_reg.imm;
        end
        we = !halt && wr && (ex_uop_reg.rd != rvx_pkg::REG_ZERO);

        pc_next      = halt ? pc_reg : npc;
        retired_next = halt ? retired_reg : retired_reg + 64'd1;

        out_next               = '0;
        out_next.next_pc       = pc_next;
        out_next.halted        = halt;
        out_next.write_enable  = we;
        out_next.write_index   = we ? ex_uop_reg.rd : '0;
        out_next.write_value   = we ? wv : '0;
        out_next.retired_count = retired_next;
        if (we && ex_uop_reg.rd == ex_uop_reg.peek)
        begin
            out_next.peek_value = wv;
        end
        else
        begin
            out_next.peek_value = reg_value(ex_uop_reg.peek, peek_data_reg, peek_wr_reg,
                                            lw_en_reg, lw_idx_reg, lw_val_reg);
        end
    end

    always_comb
    begin
        if (ex_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            lw_en_reg      <= 1'b0;
            rf_written_reg <= '0;
            pc_reg         <= '0;
            retired_reg    <= '0;
        end
        else
        begin
            ex_valid_reg  <= ex_valid_next;
            out_valid_reg <= out_valid_next;
            lw_en_reg     <= ex_fire && we;
            if (ex_fire)
            begin
                pc_reg      <= pc_next;
                retired_reg <= retired_next;
                if (we)
                begin
                    rf_written_reg[ex_uop_reg.rd] <= 1'b1;
                end
            end
        end
    end

    // Payload registers; reads use the addresses of the next execute entry
    always_ff @(posedge clk)
    begin
        ex_uop_reg  <= ex_uop_next;
        lw_idx_reg  <= ex_uop_reg.rd;
        lw_val_reg  <= wv;
        rs1_wr_reg  <= rf_written_reg[ex_uop_next.rs1];
        rs2_wr_reg  <= rf_written_reg[ex_uop_next.rs2];
        peek_wr_reg <= rf_written_reg[ex_uop_next.peek];
        if (ex_fire)
        begin
            out_reg <= out_next;
        end
    end

    // Source operand copy of the register file
    always_ff @(posedge clk)
    begin
        if (ex_fire && we)
        begin
            rf_src_mem[ex_uop_reg.rd] <= wv;
        end
        rs1_data_reg <= rf_src_mem[ex_uop_next.rs1];
        rs2_data_reg <= rf_src_mem[ex_uop_next.rs2];
    end

    // Peek copy of the register file
    always_ff @(posedge clk)
    begin
        if (ex_fire && we)
        begin
            rf_peek_mem[ex_uop_reg.rd] <= wv;
        end
        peek_data_reg <= rf_peek_mem[ex_uop_next.peek];
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Assertions
    a_x0_never_written: assert property (@(posedge clk) disable iff (!rst_n)
        (ex_fire && we) |-> ex_uop_reg.rd != rvx_pkg::REG_ZERO)
        else $error("write to x0");

    a_halt_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.halted && out_reg.write_enable))
        else $error("halted result carries a register write");

    a_retire_step: assert property (@(posedge clk) disable iff (!rst_n)
        (ex_fire && !halt) |=> retired_reg == $past(retired_reg) + 64'd1)
        else $error("retire count did not advance");

    a_pc_hold_on_halt: assert property (@(posedge clk) disable iff (!rst_n)
        (ex_fire && halt) |=> $stable(pc_reg) && $stable(retired_reg))
        else $error("state changed on halt");

endmodule

// ----- rtl/rv32i_subset_execute_core.sv -----
// Top level of the RV32I subset execute core: front end, queue and back end.
`timescale 1ns / 1ps
// Usage:
//   Input channel (instr_valid / instr_stall / instr) carries one instruction word,
//   fetched outside at the pc last reported, plus a register number to peek.
//   Output channel (result_valid / result_stall / result) carries one result per
//   instruction: next pc, halt flag, register write, peek value and retire count.
//   A transaction moves at a rising edge with valid high and stall low.
// Path: the input is decoded into the queue, the register file is read into the
//   execute stage, then the execute result is written into the output register.
// Throughput: one instruction per cycle while result_stall is low; the execute stage
//   resolves the pc and register dependences between neighbors with a write bypass.
// Halt: a zero word, or pc + 3 >= MEM_BYTES, reports halted and keeps all state.
// Reset: registers read zero except x2 = MEM_BYTES, pc and retire count are zero;
//   the block takes input as soon as reset is released.
// Stall: while result_stall is high the result holds; the execute stage and the
//   two-entry queue fill, after which instr_stall rises.
module rv32i_subset_execute_core
#(
    parameter int unsigned MEM_BYTES = rvx_pkg::MEM_BYTES_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               instr_valid,
    output logic               instr_stall,
    input  rvx_pkg::instr_t    instr,
    output logic               result_valid,
    input  logic               result_stall,
    output rvx_pkg::result_t   result
);

    logic               q_full;
    logic               push;
    logic               pop;
    rvx_pkg::uop_t      push_uop;
    rvx_pkg::q_head_t   head;

    rvx_front u_front
    (
        .instr_valid (instr_valid),
        .instr_stall (instr_stall),
        .instr       (instr),
        .q_full      (q_full),
        .push        (push),
        .uop         (push_uop)
    );

    rvx_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_uop (push_uop),
        .full     (q_full),
        .pop      (pop),
        .head     (head)
    );

    rvx_back
    #(
        .MEM_BYTES (MEM_BYTES)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
